### hw/rtl/aspq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ascending priority queue package
// Shared sizes, operation codes and result codes of the sorted-array queue.
// ----------------------------------------------------------------------------
package aspq_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int OCCUPANCY_W = 5;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

### hw/rtl/ascending_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ascending priority queue
// Sorted-array priority queue of signed 32-bit values held in one RAM.
// ----------------------------------------------------------------------------
// The queue keeps up to CAPACITY values in ascending order in a RAM, packed
// from slot 0. An insert places the value ahead of any equal values; a delete
// returns the smallest value. Each request yields one result beat with a
// status, the removed value and the new occupancy. One request is handled at
// a time and the RAM is touched once per shifted slot: an insert into a
// non-empty queue scans down from the last value, moving each value not
// below the new one up a slot; a delete reads the head and moves each later
// value down a slot; an insert into an empty queue, a refused insert or a
// delete from an empty queue goes straight to the result. A new request is
// taken while the previous result is still waiting on the output.
module ascending_priority_queue #(
    parameter int CAPACITY = aspq_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // action[0], value[32:1], zero fill above
    input  wire logic [aspq_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], removed_value[33:2], occupancy[38:34], zero fill above
    output logic      [aspq_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int VW     = aspq_pkg::VALUE_W;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_SCAN  = 6'b000010,
        S_INS_PLACE = 6'b000100,
        S_DEL_HEAD  = 6'b001000,
        S_DEL_SHIFT = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic        [CNT_W-1:0]           count_reg, count_next;
    logic        [ADDR_W-1:0]          idx_reg, idx_next;
    logic signed [VW-1:0]              val_reg, val_next;
    logic        [aspq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic        [VW-1:0]              removed_reg, removed_next;
    logic                              m_valid_reg, m_valid_next;
    logic        [aspq_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [VW-1:0]         wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [VW-1:0]         rd_data;

    logic                  in_fire;
    logic                  in_action;
    logic signed [VW-1:0]  in_value;
    logic [CNT_W-1:0]      last_idx;
    logic [CNT_W+4:0]      occ_ext;

    aspq_ram #(
        .WIDTH(VW),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_action = s_tdata[0];
    assign in_value  = $signed(s_tdata[VW:1]);
    assign last_idx  = count_reg - 1'b1;
    assign occ_ext   = {5'b0, count_reg};
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    val_next     = in_value;
                    status_next  = aspq_pkg::ST_DONE;
                    removed_next = '0;
                    if (in_action == aspq_pkg::ACT_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = aspq_pkg::ST_FULL;
                            state_next  = S_RESP;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = in_value;
                            count_next = count_reg + 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_W'(last_idx);
                            idx_next   = ADDR_W'(last_idx);
                            state_next = S_INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = aspq_pkg::ST_EMPTY;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = S_DEL_HEAD;
                        end
                    end
                end
            end

            S_INS_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + 1'b1;
                if ($signed(rd_data) < val_reg)
                begin
                    wr_data    = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PLACE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - 1'b1;
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end

            S_INS_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = val_reg;
                count_next = count_reg + 1'b1;
                state_next = S_RESP;
            end

            S_DEL_HEAD:
            begin
                removed_next = rd_data;
                if (count_reg == CNT_W'(1))
                begin
                    count_next = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(1);
                    idx_next   = ADDR_W'(1);
                    state_next = S_DEL_SHIFT;
                end
            end

            S_DEL_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg - 1'b1;
                wr_data = rd_data;
                if (CNT_W'(idx_reg) == last_idx)
                begin
                    count_next = last_idx;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, occ_ext[4:0], removed_reg, status_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        m_data_reg  <= m_data_next;
    end

endmodule
`default_nettype wire

### hw/rtl/aspq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module aspq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire
